@@ src/fpw_pkg.sv @@
`default_nettype none

package fpw_pkg;

    // Command codes on the input channel
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Page size codes
    localparam logic [1:0] PAGE_4K = 2'd0;
    localparam logic [1:0] PAGE_2M = 2'd1;
    localparam logic [1:0] PAGE_1G = 2'd2;

    // Walk levels
    localparam logic [1:0] LVL_TOP  = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_DIR  = 2'd2;
    localparam logic [1:0] LVL_TBL  = 2'd3;

    // Register indexes on the configuration port
    localparam logic REG_PROCESS_ROOT  = 1'b0;
    localparam logic REG_RESERVED_MASK = 1'b1;

    localparam int VA_W   = 64;
    localparam int PA_W   = 52;
    localparam int ADDR_W = 4;

    // Entry bits and masks
    localparam int PRESENT_POS = 0;
    localparam int LARGE_POS   = 7;
    localparam logic [PA_W-1:0] TABLE_MASK     = 52'hFFFFFFFFFF000;
    localparam logic [PA_W-1:0] HUGE_BASE_MASK = 52'hFFFFFC0000000;
    localparam logic [PA_W-1:0] BIG_BASE_MASK  = 52'hFFFFFFFE00000;
    localparam logic [PA_W-1:0] HUGE_OFF_MASK  = 52'h000003FFFFFFF;
    localparam logic [PA_W-1:0] BIG_OFF_MASK   = 52'h00000001FFFFF;
    localparam logic [PA_W-1:0] SMALL_OFF_MASK = 52'h0000000000FFF;

    typedef struct packed {
        logic [63:0] process_root;
        logic [63:0] reserved_mask;
    } fpw_cfg_t;

    typedef struct packed {
        logic        cmd;
        logic [63:0] virt_addr;
        logic [63:0] root_address;
        logic        use_process_root;
        logic [63:0] read_data;
        logic        read_error;
    } fpw_item_t;

    typedef struct packed {
        logic            kind;
        logic [63:0]     read_address;
        logic [PA_W-1:0] phys_addr;
        logic            fault;
        logic [1:0]      fault_level;
        logic [1:0]      page_size;
    } fpw_result_t;

    // Byte offset of the 8-byte entry for a level: 9-bit index times 8
    function automatic logic [63:0] slot_offset(input logic [63:0] va,
                                                input logic [1:0]  lvl);
        logic [8:0] idx;
        begin
            case (lvl)
                LVL_TOP:  idx = va[47:39];
                LVL_PDPT: idx = va[38:30];
                LVL_DIR:  idx = va[29:21];
                LVL_TBL:  idx = va[20:12];
                default:  idx = va[20:12];
            endcase
            slot_offset = {52'd0, idx, 3'b000};
        end
    endfunction

endpackage

`default_nettype wire

@@ src/four_level_page_walker.sv @@
`default_nettype none

// Four-level page table walker. A start transfer (cmd 0) gives the address
// to translate and a root base; the walker answers with a table read
// request, and each data transfer (cmd 1) carrying an entry answers with the
// next read request or the finished translation (physical address and page
// size, or a fault with its level). Data transfers while no walk is active
// are dropped; a start during a walk abandons it. One transfer is accepted
// per cycle while in_stall is low: each passes an input register, the
// mask/add logic that also updates the walk state, and a result register
// that offers its result on the output. process_root (byte 0) and
// reserved_mask (byte 8) are written over the APB port; the user must write
// them only while no walk is outstanding, as the block does not enforce it.
module four_level_page_walker
    import fpw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [63:0]       pwdata,
    output logic      [63:0]       prdata,
    output logic                   pready,
    // input channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              cmd,
    input  wire logic [63:0]       virt_addr,
    input  wire logic [63:0]       root_address,
    input  wire logic              use_process_root,
    input  wire logic [63:0]       read_data,
    input  wire logic              read_error,
    // output channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   kind,
    output logic      [63:0]       read_address,
    output logic      [PA_W-1:0]   phys_addr,
    output logic                   fault,
    output logic      [1:0]        fault_level,
    output logic      [1:0]        page_size
);

    fpw_cfg_t    cfg;
    fpw_item_t   item_reg;
    logic        item_valid_reg;
    fpw_result_t res;
    fpw_result_t res_reg;
    logic        res_valid_reg;
    logic        has_result;
    logic        out_free;
    logic        step;
    logic        in_take;

    assign pready = 1'b1;

    fpw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Stage advance: the item leaves when its result has room or it has none
    assign out_free = !res_valid_reg || !out_stall;
    assign step     = item_valid_reg && (out_free || !has_result);
    assign in_stall = item_valid_reg && !step;
    assign in_take  = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.cmd              <= cmd;
            item_reg.virt_addr        <= virt_addr;
            item_reg.root_address     <= root_address;
            item_reg.use_process_root <= use_process_root;
            item_reg.read_data        <= read_data;
            item_reg.read_error       <= read_error;
        end
    end

    fpw_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .item       (item_reg),
        .cfg        (cfg),
        .has_result (has_result),
        .result     (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= step && has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && step && has_result)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = res_valid_reg;
    assign kind         = res_reg.kind;
    assign read_address = res_reg.read_address;
    assign phys_addr    = res_reg.phys_addr;
    assign fault        = res_reg.fault;
    assign fault_level  = res_reg.fault_level;
    assign page_size    = res_reg.page_size;

`ifndef SYNTHESIS
    // The input side only waits on a held item
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid_reg)
        else $error("input stalled with an empty stage");

    // A read request never reports a fault or a page
    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_READ) |-> (!fault && page_size == PAGE_4K
            && phys_addr == '0))
        else $error("read request carries translation fields");

    // A fault gives address zero and no read address
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fault) |-> (kind == KIND_DONE && phys_addr == '0
            && read_address == 64'd0 && page_size == PAGE_4K))
        else $error("fault result with nonzero fields");

    // A stalled item that produces no result still leaves the stage
    a_drop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !has_result) |-> step)
        else $error("resultless item held in stage");
`endif

endmodule

`default_nettype wire

@@ src/fpw_cfg.sv @@
`default_nettype none

module fpw_cfg
    import fpw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [63:0]       pwdata,
    output logic      [63:0]       prdata,
    output fpw_cfg_t               cfg
);

    logic [63:0] root_reg;
    logic [63:0] mask_reg;
    logic        reg_sel;
    logic        wr_en;

    // Registers sit 8 bytes apart
    assign reg_sel = paddr[3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
            mask_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_PROCESS_ROOT:  root_reg <= pwdata;
                REG_RESERVED_MASK: mask_reg <= pwdata;
                default:           root_reg <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_PROCESS_ROOT:  prdata = root_reg;
            REG_RESERVED_MASK: prdata = mask_reg;
            default:           prdata = root_reg;
        endcase
    end

    assign cfg.process_root  = root_reg;
    assign cfg.reserved_mask = mask_reg;

endmodule

`default_nettype wire

@@ src/fpw_walk.sv @@
`default_nettype none

module fpw_walk
    import fpw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire fpw_item_t   item,
    input  wire fpw_cfg_t    cfg,
    output logic             has_result,
    output fpw_result_t      result
);

    logic        busy_reg, busy_next;
    logic [1:0]  level_reg, level_next;
    logic [63:0] va_reg, va_next;

    logic [63:0] entry;
    logic [PA_W-1:0] entry_pa;
    logic        bad_entry;
    logic        large_page;
    logic [63:0] root;
    logic [1:0]  lvl_inc;

    assign entry      = item.read_data;
    assign entry_pa   = entry[PA_W-1:0];
    assign large_page = entry[LARGE_POS];
    assign bad_entry  = item.read_error || !entry[PRESENT_POS]
                        || ((entry & cfg.reserved_mask) != 64'd0);
    assign root       = item.use_process_root ? cfg.process_root : item.root_address;
    assign lvl_inc    = level_reg + 2'd1;

    // Next walk state and the result of the item in the stage
    always_comb
    begin
        busy_next  = busy_reg;
        level_next = level_reg;
        va_next    = va_reg;
        has_result = 1'b1;
        result     = '0;
        if (item.cmd == CMD_START)
        begin
            busy_next           = 1'b1;
            level_next          = LVL_TOP;
            va_next             = item.virt_addr;
            result.kind         = KIND_READ;
            result.read_address = root + slot_offset(item.virt_addr, LVL_TOP);
        end
        else if (!busy_reg)
        begin
            has_result = 1'b0;
        end
        else if (bad_entry)
        begin
            busy_next          = 1'b0;
            level_next         = LVL_TOP;
            result.kind        = KIND_DONE;
            result.fault       = 1'b1;
            result.fault_level = level_reg;
        end
        else if (level_reg == LVL_PDPT && large_page)
        begin
            busy_next        = 1'b0;
            level_next       = LVL_TOP;
            result.kind      = KIND_DONE;
            result.phys_addr = (entry_pa & HUGE_BASE_MASK)
                               | (va_reg[PA_W-1:0] & HUGE_OFF_MASK);
            result.page_size = PAGE_1G;
        end
        else if (level_reg == LVL_DIR && large_page)
        begin
            busy_next        = 1'b0;
            level_next       = LVL_TOP;
            result.kind      = KIND_DONE;
            result.phys_addr = (entry_pa & BIG_BASE_MASK)
                               | (va_reg[PA_W-1:0] & BIG_OFF_MASK);
            result.page_size = PAGE_2M;
        end
        else if (level_reg == LVL_TBL)
        begin
            busy_next        = 1'b0;
            level_next       = LVL_TOP;
            result.kind      = KIND_DONE;
            result.phys_addr = (entry_pa & TABLE_MASK)
                               | (va_reg[PA_W-1:0] & SMALL_OFF_MASK);
            result.page_size = PAGE_4K;
        end
        else
        begin
            // Descend: next table base and the index of the next level
            level_next          = lvl_inc;
            result.kind         = KIND_READ;
            result.read_address = {12'd0, entry_pa & TABLE_MASK}
                                  | slot_offset(va_reg, lvl_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            level_reg <= LVL_TOP;
            va_reg    <= '0;
        end
        else if (step)
        begin
            busy_reg  <= busy_next;
            level_reg <= level_next;
            va_reg    <= va_next;
        end
    end

endmodule

`default_nettype wire
